### rtl/core/fcc_pkg.sv
// Shared types and constants for the footprint chunk coverage block.
// No dependencies; compile first.
`default_nettype none

package fcc_pkg;

  localparam int CELL_W    = 13;  // cell coordinates and config registers
  localparam int SIDE_W    = 4;   // footprint side in cells
  localparam int INDEX_W   = 24;  // linear chunk index
  localparam int CFG_IDX_W = 1;   // two config registers

  localparam logic [CFG_IDX_W-1:0] REG_LANDSCAPE_CELLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE      = 1'b1;

  localparam logic [CELL_W-1:0] LANDSCAPE_RESET = 13'd1024;
  localparam logic [CELL_W-1:0] CHUNK_RESET     = 13'd32;

  // Order in which the shared divider is fed.
  typedef enum logic [2:0] {
    DIV_PER_SIDE,
    DIV_FIRST_X,
    DIV_FIRST_Y,
    DIV_LAST_X,
    DIV_LAST_Y
  } div_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/fcc_if.sv
// Valid/ready channel interfaces: footprint input and chunk result output.
// Depends on fcc_pkg.
`default_nettype none

interface fcc_fp_if;
  logic                         valid;
  logic                         ready;
  logic [fcc_pkg::CELL_W-1:0]   corner_x;
  logic [fcc_pkg::CELL_W-1:0]   corner_y;
  logic [fcc_pkg::SIDE_W-1:0]   width_cells;
  logic [fcc_pkg::SIDE_W-1:0]   height_cells;

  modport source (output valid, corner_x, corner_y, width_cells, height_cells, input ready);
  modport sink   (input valid, corner_x, corner_y, width_cells, height_cells, output ready);
endinterface

interface fcc_chunk_if;
  logic                         valid;
  logic                         ready;
  logic [fcc_pkg::INDEX_W-1:0]  chunk_index;
  logic                         last_chunk;

  modport source (output valid, chunk_index, last_chunk, input ready);
  modport sink   (input valid, chunk_index, last_chunk, output ready);
endinterface

`default_nettype wire

### rtl/core/footprint_chunk_coverage.sv
// Top level: lists the grid chunks covered by a footprint, one beat per chunk.
// Depends on fcc_pkg and the channel interfaces in fcc_if.sv.
// Single module; the divider and index walker are shared in-house datapath.
//
//   channel    | dir | beat contents                                   | handshake
//   -----------+-----+-------------------------------------------------+----------
//   footprint  | in  | corner_x, corner_y, width_cells, height_cells   | valid/ready
//   chunks     | out | chunk_index, last_chunk                         | valid/ready
//   cfg        | in  | cfg_index, cfg_data                             | cfg_we only
//
// Sequence: a footprint takes 5 divisions on one restoring divider, then the row
//   base multiply, then one emitted chunk per cycle (1..MAX_FOOTPRINT^2) while
//   chunks.ready is high; the next footprint is taken once the block is idle
//   again after the last beat.
// A disabled grid or a corner off the landscape is dropped at accept, no beats.
// Reset (rst, synchronous): back to idle, registers to 1024 / 32 cells.
// Output stalls hold the current chunk; footprint.ready is high only when idle.
`default_nettype none

module footprint_chunk_coverage #(
  parameter int MAX_FOOTPRINT = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fcc_pkg::CELL_W-1:0]       cfg_data,
  fcc_fp_if.sink                                footprint,
  fcc_chunk_if.source                           chunks
);

  localparam int CW        = fcc_pkg::CELL_W;
  localparam int SW        = fcc_pkg::SIDE_W;
  localparam int IW        = fcc_pkg::INDEX_W;
  localparam int DVD_W     = CW + 1;               // lc + cs - 1 needs one more bit
  localparam int DIV_STEPS = DVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int PROD_W    = CW + CW;

  // config registers
  logic [CW-1:0] landscape_cells;
  logic [CW-1:0] chunk_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      landscape_cells <= fcc_pkg::LANDSCAPE_RESET;
      chunk_size      <= fcc_pkg::CHUNK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fcc_pkg::REG_LANDSCAPE_CELLS: landscape_cells <= cfg_data;
        fcc_pkg::REG_CHUNK_SIZE:      chunk_size      <= cfg_data;
        default: ;
      endcase
    end
  end

  fcc_pkg::state_t   state, state_next;
  fcc_pkg::div_sel_t div_sel;
  logic [STEP_W-1:0] step;

  // footprint registers
  logic [CW-1:0] x_r, y_r, ex_r, ey_r;
  // divider
  logic [DVD_W-1:0] dvd;
  logic [CW-1:0]    rem;
  // quotients
  logic [CW-1:0] per_side, fx, fy, lx, ly;
  // walker
  logic [CW-1:0] cx, cy;
  logic [IW-1:0] row_base;

  // accept-time checks and edge clamp
  logic            accept, enable;
  logic [SW-1:0]   w_eff, h_eff;
  logic [DVD_W-1:0] ex_sum, ey_sum;
  logic [CW-1:0]   lc_m1, ex_in, ey_in;
  logic [DVD_W-1:0] per_side_dvd;

  always_comb begin
    accept = footprint.valid && footprint.ready;
    enable = (chunk_size != '0) && (landscape_cells != '0) &&
             (footprint.corner_x < landscape_cells) &&
             (footprint.corner_y < landscape_cells);

    // zero side counts as one cell, oversize saturates
    if (footprint.width_cells == '0)
      w_eff = SW'(1);
    else if (footprint.width_cells > SW'(MAX_FOOTPRINT))
      w_eff = SW'(MAX_FOOTPRINT);
    else
      w_eff = footprint.width_cells;
    if (footprint.height_cells == '0)
      h_eff = SW'(1);
    else if (footprint.height_cells > SW'(MAX_FOOTPRINT))
      h_eff = SW'(MAX_FOOTPRINT);
    else
      h_eff = footprint.height_cells;

    lc_m1  = landscape_cells - CW'(1);
    ex_sum = {1'b0, footprint.corner_x} + DVD_W'(w_eff) - DVD_W'(1);
    ey_sum = {1'b0, footprint.corner_y} + DVD_W'(h_eff) - DVD_W'(1);
    ex_in  = (ex_sum > {1'b0, lc_m1}) ? lc_m1 : ex_sum[CW-1:0];
    ey_in  = (ey_sum > {1'b0, lc_m1}) ? lc_m1 : ey_sum[CW-1:0];

    per_side_dvd = {1'b0, landscape_cells} + {1'b0, chunk_size} - DVD_W'(1);
  end

  // divider step: shift in one dividend bit, subtract when it fits
  logic [DVD_W-1:0] trial, trial_sub;
  logic             fits;
  logic             div_done;
  logic [DVD_W-1:0] next_operand;
  logic [PROD_W-1:0] base_prod;

  always_comb begin
    trial     = {rem, dvd[DVD_W-1]};
    fits      = trial >= {1'b0, chunk_size};
    trial_sub = trial - {1'b0, chunk_size};
    div_done  = (step == STEP_W'(DIV_STEPS - 1));
    case (div_sel)
      fcc_pkg::DIV_PER_SIDE: next_operand = {1'b0, x_r};
      fcc_pkg::DIV_FIRST_X:  next_operand = {1'b0, y_r};
      fcc_pkg::DIV_FIRST_Y:  next_operand = {1'b0, ex_r};
      default:               next_operand = {1'b0, ey_r};
    endcase
    base_prod = fy * per_side;
  end

  logic row_end, col_end_last;
  always_comb begin
    row_end      = (cx == lx);
    col_end_last = row_end && (cy == ly);
  end

  // FSM next state
  always_comb begin
    state_next = state;
    case (state)
      fcc_pkg::ST_IDLE: if (accept && enable) state_next = fcc_pkg::ST_DIV;
      fcc_pkg::ST_DIV:  if (div_done && div_sel == fcc_pkg::DIV_LAST_Y)
                          state_next = fcc_pkg::ST_MUL;
      fcc_pkg::ST_MUL:  state_next = fcc_pkg::ST_EMIT;
      fcc_pkg::ST_EMIT: if (chunks.ready && col_end_last) state_next = fcc_pkg::ST_IDLE;
      default:          state_next = fcc_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    footprint.ready   = (state == fcc_pkg::ST_IDLE);
    chunks.valid      = (state == fcc_pkg::ST_EMIT);
    chunks.chunk_index = row_base + IW'(cx);
    chunks.last_chunk  = col_end_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fcc_pkg::ST_IDLE;
      div_sel <= fcc_pkg::DIV_PER_SIDE;
      step    <= '0;
    end else begin
      state <= state_next;
      case (state)
        fcc_pkg::ST_IDLE: begin
          div_sel <= fcc_pkg::DIV_PER_SIDE;
          step    <= '0;
        end
        fcc_pkg::ST_DIV: begin
          if (div_done) begin
            step <= '0;
            if (div_sel != fcc_pkg::DIV_LAST_Y)
              div_sel <= fcc_pkg::div_sel_t'(div_sel + 3'd1);
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      fcc_pkg::ST_IDLE: begin
        x_r  <= footprint.corner_x;
        y_r  <= footprint.corner_y;
        ex_r <= ex_in;
        ey_r <= ey_in;
        dvd  <= per_side_dvd;
        rem  <= '0;
      end
      fcc_pkg::ST_DIV: begin
        if (div_done) begin
          case (div_sel)
            fcc_pkg::DIV_PER_SIDE: per_side <= {dvd[CW-2:0], fits};
            fcc_pkg::DIV_FIRST_X:  fx       <= {dvd[CW-2:0], fits};
            fcc_pkg::DIV_FIRST_Y:  fy       <= {dvd[CW-2:0], fits};
            fcc_pkg::DIV_LAST_X:   lx       <= {dvd[CW-2:0], fits};
            default:               ly       <= {dvd[CW-2:0], fits};
          endcase
          dvd <= next_operand;
          rem <= '0;
        end else begin
          dvd <= {dvd[DVD_W-2:0], fits};
          rem <= fits ? trial_sub[CW-1:0] : trial[CW-1:0];
        end
      end
      fcc_pkg::ST_MUL: begin
        row_base <= base_prod[IW-1:0];
        cx       <= fx;
        cy       <= fy;
      end
      fcc_pkg::ST_EMIT: begin
        if (chunks.ready) begin
          if (row_end) begin
            cx       <= fx;
            cy       <= cy + CW'(1);
            row_base <= row_base + IW'(per_side);
          end else begin
            cx <= cx + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/fcc_checker.sv
// Port-level checker for footprint_chunk_coverage, with its bind.
// Depends on the top level's port names only.
`default_nettype none

module fcc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] out_index,
  input wire logic        out_last
);

  // never takes a footprint while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("footprint accepted while chunks pending");

  // the marked beat closes the footprint
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("chunk beat after last_chunk");

  // reset leaves no result on the port
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_last))
    else $error("stalled chunk beat changed");

endmodule

bind footprint_chunk_coverage fcc_checker u_fcc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (footprint.valid),
  .in_ready  (footprint.ready),
  .out_valid (chunks.valid),
  .out_ready (chunks.ready),
  .out_index (chunks.chunk_index),
  .out_last  (chunks.last_chunk)
);

`default_nettype wire

### verif/tb_footprint_chunk_coverage.sv
// Self-checking testbench for footprint_chunk_coverage: directed and random footprints,
// chunk beats predicted in the bench and checked in order. Needs fcc_pkg, fcc_if.sv and
// the block itself; nothing else.
`default_nettype none

module tb_footprint_chunk_coverage;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELL_W    = fcc_pkg::CELL_W;
  localparam int SIDE_W    = fcc_pkg::SIDE_W;
  localparam int INDEX_W   = fcc_pkg::INDEX_W;
  localparam int CFG_IDX_W = fcc_pkg::CFG_IDX_W;
  localparam int MAX_SIDE  = 8;

  // The block is idle as soon as the last owed beat of a footprint is taken;
  // this pause is margin before any register write and at the end.
  localparam int DRAIN_CYCLES = 160;
  // Receiver hold-off length for the backpressure test, counted by the sink process.
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 48;

  typedef struct packed {
    logic [INDEX_W-1:0] chunk_index;
    logic               last_chunk;
  } chunk_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = fcc_pkg::REG_LANDSCAPE_CELLS;
  logic [CELL_W-1:0]    cfg_data  = '0;

  fcc_fp_if    fp_bus ();
  fcc_chunk_if chunk_bus ();

  footprint_chunk_coverage #(
    .MAX_FOOTPRINT(MAX_SIDE)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .footprint (fp_bus),
    .chunks    (chunk_bus)
  );

  always #2 clk = ~clk;

  // Bench copy of the two registers, updated at every write.
  int unsigned grid_cells;
  int unsigned chunk_cells;

  chunk_beat_t pending_chunks[$];   // chunk beats still owed by the block, oldest first
  chunk_beat_t want;

  int errors;
  int beats_seen;
  int footprints_sent;
  int footprints_dropped;
  int settings_used;

  bit calm;       // no idling on either side while set
  bit hold_req;   // asks the sink for one long hold-off

  initial begin
    fp_bus.valid        = 1'b0;
    fp_bus.corner_x     = '0;
    fp_bus.corner_y     = '0;
    fp_bus.width_cells  = '0;
    fp_bus.height_cells = '0;
    chunk_bus.ready     = 1'b0;
  end

  // Footprint side as the block sees it: zero means one cell, large sides saturate at 8.
  function automatic int unsigned eff_side(input logic [SIDE_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_SIDE) return MAX_SIDE;
    return 32'(raw);
  endfunction

  // Works out every chunk covered by one footprint under the current registers and
  // queues the beats, row by row with ascending column.
  function automatic void cover_footprint(input logic [CELL_W-1:0] x,
                                          input logic [CELL_W-1:0] y,
                                          input logic [SIDE_W-1:0] w_raw,
                                          input logic [SIDE_W-1:0] h_raw);
    int unsigned per_side, ex, ey, fx, fy, lx, ly, cx, cy;
    chunk_beat_t beat;
    if (chunk_cells == 0 || grid_cells == 0 || x >= grid_cells || y >= grid_cells) begin
      footprints_dropped++;
      return;
    end
    per_side = (grid_cells + chunk_cells - 1) / chunk_cells;
    // clamp the far corner to the landscape edge
    ex = x + eff_side(w_raw) - 1;
    if (ex > grid_cells - 1) ex = grid_cells - 1;
    ey = y + eff_side(h_raw) - 1;
    if (ey > grid_cells - 1) ey = grid_cells - 1;
    fx = x / chunk_cells;
    fy = y / chunk_cells;
    lx = ex / chunk_cells;
    ly = ey / chunk_cells;
    if (lx > per_side - 1) lx = per_side - 1;
    if (ly > per_side - 1) ly = per_side - 1;
    for (cy = fy; cy <= ly; cy++) begin
      for (cx = fx; cx <= lx; cx++) begin
        // index keeps its low 24 bits when out-of-range registers overflow it
        beat.chunk_index = INDEX_W'(cy * per_side + cx);
        beat.last_chunk  = (cy == ly) && (cx == lx);
        pending_chunks = {pending_chunks, beat};
      end
    end
  endfunction

  // One footprint beat: random gap, then hold valid until the block takes it.
  task automatic send_footprint(input logic [CELL_W-1:0] x, input logic [CELL_W-1:0] y,
                                input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap != 0) begin
      fp_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    fp_bus.valid        <= 1'b1;
    fp_bus.corner_x     <= x;
    fp_bus.corner_y     <= y;
    fp_bus.width_cells  <= w;
    fp_bus.height_cells <= h;
    do @(posedge clk); while (fp_bus.ready !== 1'b1);
    footprints_sent++;
    cover_footprint(x, y, w, h);
  endtask

  // Drop valid, wait for every owed beat, then let the block settle.
  task automatic drain;
    @(negedge clk);
    fp_bus.valid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CELL_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == fcc_pkg::REG_LANDSCAPE_CELLS) grid_cells = value & 13'h1FFF;
    else chunk_cells = value & 13'h1FFF;
  endtask

  task automatic set_grid(input int unsigned lc, input int unsigned cs);
    write_cfg(fcc_pkg::REG_LANDSCAPE_CELLS, lc);
    write_cfg(fcc_pkg::REG_CHUNK_SIZE, cs);
    settings_used++;
  endtask

  // Mostly corners on the landscape, some hugging the far edge, a few anywhere.
  task automatic random_footprint;
    int unsigned sel, off;
    logic [CELL_W-1:0] x, y;
    logic [SIDE_W-1:0] w, h;
    sel = $urandom_range(0, 99);
    off = $urandom_range(0, 7);
    if (sel < 75 && grid_cells > 0) begin
      x = CELL_W'($urandom_range(0, grid_cells - 1));
      y = CELL_W'($urandom_range(0, grid_cells - 1));
    end else if (sel < 90 && grid_cells > 0) begin
      x = (off < grid_cells) ? CELL_W'(grid_cells - 1 - off) : '0;
      y = (sel[0] && grid_cells > 1) ? CELL_W'($urandom_range(0, grid_cells - 1)) : x;
    end else begin
      x = CELL_W'($urandom);
      y = CELL_W'($urandom);
    end
    sel = $urandom_range(0, 99);
    w = (sel < 85) ? SIDE_W'($urandom_range(0, 8)) : SIDE_W'($urandom_range(0, 15));
    h = (sel < 70 || sel >= 85) ? SIDE_W'($urandom_range(0, 8))
                                : SIDE_W'($urandom_range(0, 15));
    send_footprint(x, y, w, h);
  endtask

  // Result sink: draws a wait before each beat; one long hold-off on request.
  initial begin : chunk_sink
    int unsigned gap;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 7);
      end
      if (gap != 0) begin
        chunk_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      chunk_bus.ready <= 1'b1;
      do @(posedge clk); while (chunk_bus.valid !== 1'b1);
    end
  end

  // Every taken beat is matched against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && chunk_bus.valid === 1'b1 && chunk_bus.ready === 1'b1) begin
      beats_seen++;
      if (pending_chunks.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected chunk beat index=%0d last=%0b",
                   chunk_bus.chunk_index, chunk_bus.last_chunk);
      end else begin
        want = pending_chunks.pop_front();
        if (chunk_bus.chunk_index !== want.chunk_index ||
            chunk_bus.last_chunk !== want.last_chunk) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: chunk beat expected index=%0d last=%0b, got index=%0d last=%0b",
                     want.chunk_index, want.last_chunk,
                     chunk_bus.chunk_index, chunk_bus.last_chunk);
        end
      end
    end
  end

  // Reset values 1024 / 32: corners, straddles, edge clamping, off-landscape corners,
  // zero and oversized sides.
  task automatic test_reset_defaults;
    calm = 1'b0;
    send_footprint(13'd0,    13'd0,    4'd0,  4'd0);
    send_footprint(13'd0,    13'd0,    4'd8,  4'd8);
    send_footprint(13'd30,   13'd30,   4'd8,  4'd8);
    send_footprint(13'd31,   13'd0,    4'd2,  4'd1);
    send_footprint(13'd1023, 13'd1023, 4'd8,  4'd8);
    send_footprint(13'd1020, 13'd0,    4'd15, 4'd0);
    send_footprint(13'd1024, 13'd0,    4'd1,  4'd1);
    send_footprint(13'd0,    13'd1024, 4'd1,  4'd1);
    send_footprint(13'd8191, 13'd8191, 4'd15, 4'd15);
    send_footprint(13'd5000, 13'd3,    4'd4,  4'd4);
    send_footprint(13'd100,  13'd200,  4'd9,  4'd3);
    drain();
  endtask

  // Zero chunk size and zero landscape both silence the block.
  task automatic test_disabled_grid;
    set_grid(1024, 0);
    send_footprint(13'd0,   13'd0,   4'd1, 4'd1);
    send_footprint(13'd500, 13'd500, 4'd8, 4'd8);
    drain();
    set_grid(0, 32);
    send_footprint(13'd0, 13'd0, 4'd1, 4'd1);
    drain();
  endtask

  // Register extremes: 64 chunks per footprint, single-chunk grids, a partial last
  // chunk, and an out-of-range landscape where the index wraps.
  task automatic test_chunk_extremes;
    set_grid(4096, 1);
    send_footprint(13'd4088, 13'd4088, 4'd8, 4'd8);
    send_footprint(13'd0,    13'd0,    4'd8, 4'd8);
    drain();
    set_grid(4096, 4096);
    send_footprint(13'd4095, 13'd4095, 4'd8, 4'd8);
    send_footprint(13'd0,    13'd0,    4'd8, 4'd8);
    drain();
    set_grid(1, 4096);
    send_footprint(13'd0, 13'd0, 4'd8, 4'd8);
    send_footprint(13'd1, 13'd0, 4'd1, 4'd1);
    drain();
    set_grid(10, 3);
    send_footprint(13'd8, 13'd8, 4'd8, 4'd8);
    drain();
    set_grid(8191, 1);
    send_footprint(13'd8183, 13'd8183, 4'd8, 4'd8);
    send_footprint(13'd8190, 13'd8190, 4'd8, 4'd8);
    drain();
  endtask

  // Random footprints under a run of settings; every third phase runs without idling.
  task automatic test_random_settings;
    int unsigned lc, cs;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin lc = 1024; cs = 32; end
        1: begin lc = 4096; cs = 1; end
        2: begin lc = 4096; cs = 4096; end
        3: begin lc = 1; cs = 1; end
        4: begin lc = 8191; cs = 7; end
        5: begin lc = $urandom_range(1, 4096); cs = $urandom_range(1, 64); end
        6: begin lc = $urandom_range(1, 4096); cs = $urandom_range(1, 4096); end
        7: begin lc = $urandom_range(0, 8191); cs = $urandom_range(1, 8191); end
        default: begin lc = $urandom_range(64, 512); cs = $urandom_range(2, 9); end
      endcase
      calm = (phase % 3 == 0);
      set_grid(lc, cs);
      repeat (ITEMS_PER_PHASE) random_footprint();
      drain();
    end
    calm = 1'b0;
  endtask

  // Receiver holds off for a long stretch while footprints keep coming, so the block
  // sits on a full output and keeps its input stalled.
  task automatic test_backpressure;
    set_grid(1024, 2);
    hold_req = 1'b1;
    repeat (6)
      send_footprint(CELL_W'($urandom_range(0, 1023)), CELL_W'($urandom_range(0, 1023)),
                     4'd8, 4'd8);
    drain();
  endtask

  initial begin : main
    grid_cells = 32'(fcc_pkg::LANDSCAPE_RESET);
    chunk_cells = 32'(fcc_pkg::CHUNK_RESET);
    errors = 0;
    beats_seen = 0;
    footprints_sent = 0;
    footprints_dropped = 0;
    settings_used = 1;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_disabled_grid();
    test_chunk_extremes();
    test_backpressure();
    test_random_settings();

    if (pending_chunks.size() != 0) begin
      errors++;
      $display("ERROR: %0d chunk beats never arrived", pending_chunks.size());
    end
    $display("summary: %0d footprints (%0d silent: off the landscape or disabled grid),",
             footprints_sent, footprints_dropped);
    $display("summary: %0d chunk beats checked across %0d register settings, %0d errors",
             beats_seen, settings_used, errors);
    if (errors == 0) begin
      $display("tb_footprint_chunk_coverage passed");
    end else begin
      $display("tb_footprint_chunk_coverage failed");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("ERROR: run timed out");
    $display("tb_footprint_chunk_coverage failed");
    $finish;
  end

endmodule

`default_nettype wire
